>>> rtl/vertical_or_line_filter_unit_defines.svh
// Assertion macros shared by the filter's modules.
`ifndef VERTICAL_OR_LINE_FILTER_UNIT_DEFINES_SVH
`define VERTICAL_OR_LINE_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VOLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VOLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/volf_pkg.sv
package volf_pkg;

    // Line store depth and the column counter that indexes it.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field widths.
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 16;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef logic [PIX_W-1:0] pix_t;

    // Register indexes.
    typedef enum logic [PADDR_W-3:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    // Frame geometry as seen by the front end.
    typedef struct packed {
        logic [COL_W-1:0]    last_col_idx;
        logic [HEIGHT_W-1:0] last_row_idx;
    } frame_cfg_t;

    // One request for the back end: one or two result pixels.
    typedef struct packed {
        pix_t pix_a;
        pix_t pix_b;
        logic dual;
        logic fend;
    } job_t;

    // Back end emission phase.
    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

endpackage

>>> rtl/volf_front.sv
`include "vertical_or_line_filter_unit_defines.svh"

module volf_front
    import volf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_cfg_t        cfg,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  logic [CHAN_W-1:0] blue_in,
    input  logic [CHAN_W-1:0] green_in,
    input  logic [CHAN_W-1:0] red_in,
    input  logic [QCNT_W-1:0] q_count,
    output logic              push,
    output job_t              push_job
);

    logic                accept;
    logic                last_col;
    logic                last_row;
    logic [QCNT_W:0]     used;

    logic [COL_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0] row_reg;

    logic                s1_valid_reg;
    logic [COL_W-1:0]    s1_x_reg;
    pix_t                s1_cur_reg;
    logic                s1_row0_reg;
    logic                s1_row1_reg;
    logic                s1_lastrow_reg;
    logic                s1_fend_reg;

    logic [2*PIX_W-1:0]  mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]  rd_reg;
    logic                byp_reg;
    logic [2*PIX_W-1:0]  byp_data_reg;

    logic [2*PIX_W-1:0]  line;
    pix_t                p1;
    pix_t                p2;
    pix_t                above;
    logic [2*PIX_W-1:0]  wdata;

    // Accept only when the queue has room for every request in flight.
    assign used      = {1'b0, q_count} + (QCNT_W+1)'(push);
    assign pix_ready = used < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept    = pix_valid && pix_ready;

    // Position of the incoming pixel within the frame.
    assign last_col = col_reg >= cfg.last_col_idx;
    assign last_row = row_reg >= cfg.last_row_idx;

    // Column and row counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Stage one control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                byp_reg <= s1_valid_reg && (s1_x_reg == col_reg);
            end
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg       <= col_reg;
            s1_cur_reg     <= {red_in, green_in, blue_in};
            s1_row0_reg    <= (row_reg == '0);
            s1_row1_reg    <= (row_reg == HEIGHT_W'(1));
            s1_lastrow_reg <= last_row;
            s1_fend_reg    <= last_row && last_col;
            byp_data_reg   <= wdata;
        end
    end

    // Line stores: the older row in the upper half, the newer row below.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mem[s1_x_reg] <= wdata;
        end
        if (accept)
        begin
            rd_reg <= mem[col_reg];
        end
    end

    // A write of the previous pixel to the same column overrides the read.
    assign line  = byp_reg ? byp_data_reg : rd_reg;
    assign p1    = line[PIX_W-1:0];
    assign p2    = line[2*PIX_W-1:PIX_W];
    assign wdata = {p1, s1_cur_reg};
    assign above = s1_row1_reg ? p1 : (p2 | p1 | s1_cur_reg);

    // Classify the pixel into a request for the back end.
    assign push           = s1_valid_reg && !(s1_row0_reg && !s1_lastrow_reg);
    assign push_job.pix_a = s1_row0_reg ? s1_cur_reg : above;
    assign push_job.pix_b = s1_cur_reg;
    assign push_job.dual  = !s1_row0_reg && s1_lastrow_reg;
    assign push_job.fend  = s1_fend_reg;

    `VOLF_ASSERT_NOW(a_front_room, push, q_count < QCNT_W'(QUEUE_DEPTH), "push into full queue")

endmodule

>>> rtl/volf_queue.sv
`include "vertical_or_line_filter_unit_defines.svh"

module volf_queue
    import volf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  job_t              push_job,
    input  logic              pop,
    output logic              q_valid,
    output job_t              q_job,
    output logic [QCNT_W-1:0] q_count
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];
    assign q_count = count_reg;

    `VOLF_ASSERT_NOW(a_queue_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule

>>> rtl/volf_back.sv
`include "vertical_or_line_filter_unit_defines.svh"

module volf_back
    import volf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  job_t              q_job,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [CHAN_W-1:0] blue_out,
    output logic [CHAN_W-1:0] green_out,
    output logic [CHAN_W-1:0] red_out,
    output logic              run_last,
    output logic              frame_end
);

    logic   load;
    phase_t phase_reg;
    phase_t phase_next;
    logic   out_valid_reg;
    pix_t   pix_reg;
    pix_t   pix_next;
    logic   run_last_reg;
    logic   run_last_next;
    logic   frame_end_reg;
    logic   frame_end_next;

    // Load the output register when a request waits and the register is empty or being drained.
    assign load = q_valid && (!out_valid_reg || res_ready);

    // Pick the next result from the request at the queue head.
    always_comb
    begin
        phase_next     = phase_reg;
        pix_next       = q_job.pix_a;
        run_last_next  = !q_job.dual;
        frame_end_next = !q_job.dual && q_job.fend;
        pop            = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (load)
                begin
                    if (q_job.dual)
                    begin
                        phase_next = PH_SECOND;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end
            PH_SECOND:
            begin
                pix_next       = q_job.pix_b;
                run_last_next  = 1'b1;
                frame_end_next = q_job.fend;
                if (load)
                begin
                    pop        = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg       <= pix_next;
            run_last_reg  <= run_last_next;
            frame_end_reg <= frame_end_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign blue_out  = pix_reg[CHAN_W-1:0];
    assign green_out = pix_reg[2*CHAN_W-1:CHAN_W];
    assign red_out   = pix_reg[3*CHAN_W-1:2*CHAN_W];
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

    `VOLF_ASSERT_NOW(a_back_hold, phase_reg == PH_SECOND, q_valid, "second half without request")
    `VOLF_ASSERT_NEXT(a_back_split, load && phase_reg == PH_FIRST && q_job.dual,
                      phase_reg == PH_SECOND, "dual request not split")
    `VOLF_ASSERT_NOW(a_back_fend, out_valid_reg && frame_end_reg, run_last_reg,
                     "frame end on non-final result")

endmodule

>>> rtl/vertical_or_line_filter_unit.sv
// Vertical 3x1 OR filter over a BGR pixel stream in raster order.
// Pixels enter on pix_valid/pix_ready with blue_in, green_in, red_in; results
// leave on res_valid/res_ready. A request is accepted when valid and ready are
// both high at a rising clock edge. Each result carries run_last, set on the
// final result caused by an input pixel, and frame_end on the frame's last pixel.
// Frame width and height are set through the APB port (width at address 0,
// height at address 4) and should only be changed while the block is idle.
// The first row produces no results unless it is also the last row; each later
// pixel produces the pixel of the row before it, and a last-row pixel also
// produces itself. A result passes the stage-one registers, the request queue
// and the output register. One pixel is accepted per cycle while the queue has
// room; on the last row the output side emits two results per pixel, so input
// then slows. The rate is set by the single output register in the back end.
// If the receiver stalls, results collect in a four-entry request queue and
// pix_ready drops once the queue could not take the requests in flight.
// Reset clears the counters, the queue and the output register, and sets the
// width to 640 and height to 480; the line stores are not cleared.
module vertical_or_line_filter_unit
    import volf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  logic [CHAN_W-1:0]  blue_in,
    input  logic [CHAN_W-1:0]  green_in,
    input  logic [CHAN_W-1:0]  red_in,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [CHAN_W-1:0]  blue_out,
    output logic [CHAN_W-1:0]  green_out,
    output logic [CHAN_W-1:0]  red_out,
    output logic               run_last,
    output logic               frame_end
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    reg_idx_t            reg_idx;
    frame_cfg_t          cfg;
    logic                push;
    job_t                push_job;
    logic                pop;
    logic                q_valid;
    job_t                q_job;
    logic [QCNT_W-1:0]   q_count;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Last column and row indexes, with zero and oversize settings clamped.
    always_comb
    begin
        if (width_reg == '0)
        begin
            cfg.last_col_idx = '0;
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            cfg.last_col_idx = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            cfg.last_col_idx = COL_W'(int'(width_reg) - 1);
        end
        cfg.last_row_idx = (height_reg == '0) ? '0 : height_reg - 1'b1;
    end

    volf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .q_count   (q_count),
        .push      (push),
        .push_job  (push_job)
    );

    volf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_count  (q_count)
    );

    volf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .blue_out  (blue_out),
        .green_out (green_out),
        .red_out   (red_out),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import volf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;

    // One filtered output pixel as the block should present it.
    typedef struct {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              run_last;
        logic              frame_end;
    } out_pixel_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               pix_valid = 1'b0;
    logic               pix_ready;
    logic [CHAN_W-1:0]  blue_in = '0;
    logic [CHAN_W-1:0]  green_in = '0;
    logic [CHAN_W-1:0]  red_in = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [CHAN_W-1:0]  blue_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  red_out;
    logic               run_last;
    logic               frame_end;

    // Model of the filter: geometry, line stores and raster position.
    logic [WIDTH_W-1:0]  cfg_width = 12'd640;
    logic [HEIGHT_W-1:0] cfg_height = 16'd480;
    pix_t                line_above [MAX_WIDTH];
    pix_t                line_above2 [MAX_WIDTH];
    int                  col_pos = 0;
    int                  row_pos = 0;
    out_pixel_t          due_pixels [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int pixels_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;

    vertical_or_line_filter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .blue_out  (blue_out),
        .green_out (green_out),
        .red_out   (red_out),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic void push_result(input pix_t pix, input logic last, input logic fend);
        out_pixel_t res;
        res.blue      = pix[7:0];
        res.green     = pix[15:8];
        res.red       = pix[23:16];
        res.run_last  = last;
        res.frame_end = fend;
        due_pixels.push_back(res);
    endfunction

    // Work out the results of one accepted pixel and advance the raster position.
    function automatic void dilate_pixel(input pix_t cur);
        int   w;
        int   h;
        int   x;
        pix_t p1;
        pix_t p2;
        bit   last_col;
        bit   last_row;
        w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        x = col_pos % MAX_WIDTH;
        p1 = line_above[x];
        p2 = line_above2[x];
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;

        if (row_pos == 0)
        begin
            // The first row is only stored, unless it is also the last one.
            if (last_row)
                push_result(cur, 1'b1, last_col);
        end
        else
        begin
            if (last_row)
            begin
                push_result((row_pos == 1) ? p1 : (p2 | p1 | cur), 1'b0, 1'b0);
                push_result(cur, 1'b1, last_col);
            end
            else
            begin
                push_result((row_pos == 1) ? p1 : (p2 | p1 | cur), 1'b1, 1'b0);
            end
        end

        line_above2[x] = p1;
        line_above[x] = cur;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every accepted result with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        out_pixel_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (due_pixels.size() == 0)
            begin
                $error("result arrived with no result expected");
                mismatches++;
            end
            else
            begin
                want = due_pixels.pop_front();
                check_field("blue_out", want.blue, blue_out);
                check_field("green_out", want.green, green_out);
                check_field("red_out", want.red, red_out);
                check_field("run_last", 8'(want.run_last), 8'(run_last));
                check_field("frame_end", 8'(want.frame_end), 8'(frame_end));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_ready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one pixel request and wait until the block accepts it.
    task automatic send_pixel(input pix_t pix);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        {red_in, green_in, blue_in} <= pix;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        dilate_pixel(pix);
        pixels_sent++;
    endtask

    // Mostly random bytes; sparse and saturated pixels make the OR visible.
    function automatic pix_t random_pixel();
        int   pick;
        pix_t pix;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            pix = pix_t'($urandom);
        end
        else if (pick < 80)
        begin
            pix = '0;
            pix[$urandom_range(PIX_W - 1)] = 1'b1;
        end
        else if (pick < 90)
        begin
            pix = '0;
        end
        else
        begin
            pix = '1;
        end
        return pix;
    endfunction

    task automatic send_pixels(input int count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    // Send pixels until the raster position is back at the start of a frame.
    task automatic send_frame();
        do
            send_pixel(random_pixel());
        while (col_pos != 0 || row_pos != 0);
    endtask

    // Stop offering pixels, wait for every result, then let the pipeline settle.
    task automatic drain();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (due_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_WIDTH)
            cfg_width = value[WIDTH_W-1:0];
        else
            cfg_height = value[HEIGHT_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_geometry(input int width, input int height);
        drain();
        write_reg(REG_WIDTH, PDATA_W'(width));
        write_reg(REG_HEIGHT, PDATA_W'(height));
    endtask

    // Zero width and zero height both behave as one.
    task automatic test_zero_sizes();
        set_geometry(0, 0);
        send_pixel(24'hA5_5A_C3);
    endtask

    // A single-row frame passes every pixel straight through.
    task automatic test_single_row_frame();
        set_geometry(3, 1);
        send_pixel(24'h00_00_00);
        send_pixel(24'hFF_FF_FF);
        send_pixel(24'h80_01_7F);
    endtask

    // In a two-row frame both rows come out unchanged.
    task automatic test_two_row_frame();
        set_geometry(2, 2);
        send_pixel(24'h01_02_03);
        send_pixel(24'h80_00_00);
        send_pixel(24'h00_00_80);
        send_pixel(24'h7F_7F_7F);
    endtask

    // Interior rows combine one bit from each neighbor.
    task automatic test_interior_rows();
        set_geometry(1, 4);
        send_pixel(24'h00_00_01);
        send_pixel(24'h00_01_00);
        send_pixel(24'h01_00_00);
        send_pixel(24'h80_80_80);
    endtask

    // Lowering the height below the current row makes that row the last one.
    task automatic test_height_change_mid_frame();
        set_geometry(1, 65535);
        send_pixels(4);
        drain();
        write_reg(REG_HEIGHT, PDATA_W'(2));
        send_frame();
    endtask

    // Narrowing the width mid-row ends the row at the current column.
    task automatic test_width_change_mid_frame();
        set_geometry(4, 3);
        send_pixels(6);
        drain();
        write_reg(REG_WIDTH, PDATA_W'(2));
        send_frame();
    endtask

    // Hold the receiver off while the sender keeps going, so the input stalls.
    task automatic test_output_backpressure();
        set_geometry(16, 4);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 150;
        send_frame();
        drain();
    endtask

    // An oversized width register must not end the first row early; the row
    // is then closed by narrowing the width, and the second row follows.
    task automatic test_oversize_width();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_geometry(4095, 2);
        send_pixels(40);
        drain();
        write_reg(REG_WIDTH, PDATA_W'(20));
        send_frame();
        drain();
    endtask

    function automatic int random_width();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(1, 8);
        else if (pick < 92)
            return $urandom_range(9, 40);
        else if (pick < 97)
            return $urandom_range(41, 160);
        return 0;
    endfunction

    function automatic int random_height();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return $urandom_range(1, 5);
        else if (pick < 95)
            return $urandom_range(6, 12);
        return 0;
    endfunction

    // Whole frames of random pixels; geometry changes only between frames.
    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int count);
        int  start;
        bit  new_width;
        bit  new_height;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = pixels_sent;
        while (pixels_sent - start < count)
        begin
            new_width = ($urandom_range(9) < 6);
            new_height = ($urandom_range(9) < 6);
            if (new_width || new_height)
                drain();
            if (new_width)
                write_reg(REG_WIDTH, PDATA_W'(random_width()));
            if (new_height)
                write_reg(REG_HEIGHT, PDATA_W'(random_height()));
            send_frame();
        end
        drain();
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_sizes();
        test_single_row_frame();
        test_two_row_frame();
        test_interior_rows();
        test_height_change_mid_frame();
        test_width_change_mid_frame();
        test_output_backpressure();
        test_oversize_width();
        test_random_frames(0, 0, 340);
        test_random_frames(52, 0, 340);
        test_random_frames(0, 52, 340);
        test_random_frames(13, 13, 340);

        drain();
        repeat (END_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && due_pixels.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/volf_pkg.sv
rtl/volf_front.sv
rtl/volf_queue.sv
rtl/volf_back.sv
rtl/vertical_or_line_filter_unit.sv
test/testbench.sv
